// File: hdl/rgrm_pkg.sv
// ============================================================================
// rgrm_pkg: shared types and constants for the range-gated running median
// Register indexes, field widths and the controller/datapath interface.
// ============================================================================
package rgrm_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int DIST_W   = 15;

    // default window depth
    localparam int WINDOW_DEF = 5;

    // configuration register indexes
    localparam int          CFG_IDX_W   = 1;
    localparam logic [0:0]  REG_MIN_DIST = 1'b0;
    localparam logic [0:0]  REG_MAX_DIST = 1'b1;

    // configuration reset values
    localparam logic [DIST_W-1:0] MIN_DIST_RST = 15'd32;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 15'd6400;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // accept a sample: gate, write window, restart scan
        logic scan_next; // current candidate missed, step to the next one
        logic hold;      // current candidate is the median, latch it
        logic emit;      // move the latched result into the output register
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic hit;       // current candidate sits at the median rank
        logic out_free;  // output register empty or being drained this cycle
    } t_dp_sts;

endpackage

// File: hdl/rgrm_ctrl.sv
// ============================================================================
// rgrm_ctrl: sequencing controller
// Accepts one sample, walks the ranking scan, then hands the result out.
// ============================================================================
module rgrm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  rgrm_pkg::t_dp_sts i_sts,
    output rgrm_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.hit) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands
    assign o_s_tready    = (r_state == S_IDLE);
    assign o_cmd.load      = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.scan_next = (r_state == S_SCAN) && !i_sts.hit;
    assign o_cmd.hold      = (r_state == S_SCAN) && i_sts.hit;
    assign o_cmd.emit      = (r_state == S_EMIT) && i_sts.out_free;

endmodule

// File: hdl/rgrm_dp.sv
// ============================================================================
// rgrm_dp: range gate, window store and rank-count median datapath
// Each scan cycle ranks one stored candidate against the written window entries.
// ============================================================================
module rgrm_dp #(
    parameter int WINDOW = rgrm_pkg::WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_wen,
    input  logic [rgrm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgrm_pkg::DIST_W-1:0]    i_cfg_wdata,
    // sample in
    input  logic [rgrm_pkg::SAMPLE_W-1:0]  i_sample,
    // result out
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_in_range,
    output logic [rgrm_pkg::DIST_W-1:0]    o_median,
    // control
    input  rgrm_pkg::t_dp_cmd              i_cmd,
    output rgrm_pkg::t_dp_sts              o_sts
);

    localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int DW    = rgrm_pkg::DIST_W;

    logic [DW-1:0]    r_min_dist;
    logic [DW-1:0]    r_max_dist;
    logic [DW-1:0]    r_win [WINDOW];
    logic [IW-1:0]    r_wslot;
    logic [CNT_W-1:0] r_fill;
    logic [IW-1:0]    r_cand;
    logic             r_rng;
    logic [DW-1:0]    r_med;
    logic             r_out_valid;
    logic             r_out_rng;
    logic [DW-1:0]    r_out_med;

    logic             w_ok;
    logic [DW-1:0]    w_val;
    logic [DW-1:0]    w_x;
    logic [CNT_W-1:0] w_rank;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= rgrm_pkg::MIN_DIST_RST;
            r_max_dist <= rgrm_pkg::MAX_DIST_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                rgrm_pkg::REG_MIN_DIST: r_min_dist <= i_cfg_wdata;
                rgrm_pkg::REG_MAX_DIST: r_max_dist <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // range gate: negative samples fail, out-of-range stores max
    assign w_ok  = !i_sample[rgrm_pkg::SAMPLE_W-1]
                && (i_sample[DW-1:0] >= r_min_dist)
                && (i_sample[DW-1:0] <= r_max_dist);
    assign w_val = w_ok ? i_sample[DW-1:0] : r_max_dist;

    // window write, slot and fill tracking
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_win[r_wslot] <= w_val;
            r_rng          <= w_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_fill  <= '0;
            r_cand  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_wslot <= (r_wslot == IW'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
                if (r_fill < CNT_W'(WINDOW)) r_fill <= r_fill + 1'b1;
                r_cand <= '0;
            end else if (i_cmd.scan_next) begin
                r_cand <= r_cand + 1'b1;
            end
        end
    end

    // rank of the candidate: entries below it, plus equal ones at lower slots
    assign w_x = r_win[r_cand];

    always_comb begin
        logic vld;
        w_rank = '0;
        for (int j = 0; j < WINDOW; j++) begin
            vld = (CNT_W'(j) < r_fill);
            if (vld && ((r_win[j] < w_x) || ((r_win[j] == w_x) && (IW'(j) < r_cand))))
                w_rank = w_rank + 1'b1;
        end
    end

    assign o_sts.hit      = (w_rank == (r_fill >> 1));
    assign o_sts.out_free = !r_out_valid || i_ready;

    // latch the median found by the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) r_med <= w_x;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_rng <= r_rng;
            r_out_med <= r_med;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_in_range = r_out_rng;
    assign o_median   = r_out_med;

endmodule

// File: hdl/range_gated_running_median.sv
// ============================================================================
// range_gated_running_median: range-gated running median for one distance channel
// Gates each sample against min/max, stores it in a circular window and
// returns the median of the entries written so far.
// ============================================================================
// Usage:
//   Slave stream carries one signed 16-bit sample per beat (1/16 cm). A sample
//   outside min..max (a negative timeout included) is stored as max_distance.
//   Master stream returns one beat per sample: median in tdata, the in-range
//   flag in tuser.
//   The config port writes min_distance (index 0) or max_distance (index 1)
//   on any cycle with i_cfg_wen high; write only while the block is idle.
//   Sequence: the sample is taken, then the stored candidates are ranked in
//   slot order until the one at the median rank is found, then the result
//   moves into the output register once it is free. The candidate scan ranks
//   one stored entry per cycle against the written entries of the window.
//   While the result waits in the output register the next sample is already
//   taken and ranked; a stalled receiver holds the finished result in the
//   output register and a second finished result back in the datapath.
//   Reset empties the window and restores min 32, max 6400.
// ============================================================================
module range_gated_running_median #(
    parameter int WINDOW = rgrm_pkg::WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_wen,
    input  logic [rgrm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgrm_pkg::DIST_W-1:0]    i_cfg_wdata,
    // sample stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [15:0]                    i_s_tdata,  // [15:0] sample
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [15:0]                    o_m_tdata,  // [14:0] median, [15] zero
    output logic                           o_m_tuser   // [0] in_range
);

    rgrm_pkg::t_dp_cmd w_cmd;
    rgrm_pkg::t_dp_sts w_sts;
    logic [rgrm_pkg::DIST_W-1:0] w_median;

    rgrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rgrm_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_s_tdata),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_in_range  (o_m_tuser),
        .o_median    (w_median),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    assign o_m_tdata = {1'b0, w_median};

endmodule

// File: tb/tb_range_gated_running_median.sv
// ============================================================================
// tb_range_gated_running_median: self-checking bench for the running median
// Drives distance samples into the slave stream and checks every median beat
// against an in-bench window model or a typed-in result. A short directed table
// covers the range edges, timeouts and inverted limits; random phases follow
// under several min/max settings, most of them with random idling on both streams.
// ============================================================================
module tb_range_gated_running_median;

    localparam int          WIN             = rgrm_pkg::WINDOW_DEF;
    localparam int          CYCLE_LIMIT     = 300000;
    localparam int          SETTLE_CYCLES   = WIN + 8;
    localparam int          RAND_PHASES     = 6;
    localparam int          ITEMS_PER_PHASE = 315;
    localparam logic [15:0] TIMEOUT_SAMPLE  = 16'hFFF0;  // -16, i.e. -1 cm

    // one result beat: gate flag and median
    typedef struct packed {
        logic                        in_range;
        logic [rgrm_pkg::DIST_W-1:0] median;
    } t_median_res;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    // directed row: a sample (optionally with a typed-in result) or a register write
    typedef struct packed {
        t_row_kind                      kind;
        logic [15:0]                    value;
        logic [rgrm_pkg::CFG_IDX_W-1:0] reg_idx;
        logic                           has_exp;
        t_median_res                    res;
    } t_dir_row;

    localparam int DIR_ROWS_N = 25;
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        // reset limits 32..6400, window filling up
        '{ROW_SAMPLE, 16'd100,        rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b1, 15'd100}},
        '{ROW_SAMPLE, TIMEOUT_SAMPLE, rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b0, 15'd6400}},
        '{ROW_SAMPLE, 16'd32,         rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b1, 15'd100}},
        '{ROW_SAMPLE, 16'd6400,       rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b1, 15'd6400}},
        '{ROW_SAMPLE, 16'd31,         rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b0, 15'd6400}},
        // full window, oldest entries overwritten by substitutes
        '{ROW_SAMPLE, 16'd6401,       rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b0, 15'd6400}},
        '{ROW_SAMPLE, 16'h8000,       rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b0, 15'd6400}},
        '{ROW_SAMPLE, 16'h7FFF,       rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b0, 15'd6400}},
        '{ROW_SAMPLE, 16'h0000,       rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b0, 15'd6400}},
        '{ROW_SAMPLE, 16'hFFFF,       rgrm_pkg::REG_MIN_DIST, 1'b1, '{1'b0, 15'd6400}},
        // mixed valid values, wrap of the write slot
        '{ROW_SAMPLE, 16'd500,        rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd40,         rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd3000,       rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd1000,       rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd200,        rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        // min above max: nothing is valid
        '{ROW_CFG,    16'd32767,      rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_CFG,    16'd0,          rgrm_pkg::REG_MAX_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd32767,      rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd0,          rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd100,        rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        // widest range: every non-negative sample is valid
        '{ROW_CFG,    16'd0,          rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_CFG,    16'd32767,      rgrm_pkg::REG_MAX_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd0,          rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_SAMPLE, 16'd32767,      rgrm_pkg::REG_MIN_DIST, 1'b0, '0},
        '{ROW_SAMPLE, TIMEOUT_SAMPLE, rgrm_pkg::REG_MIN_DIST, 1'b0, '0}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wen;
    logic [rgrm_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [rgrm_pkg::DIST_W-1:0]    i_cfg_wdata;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [15:0]                    i_s_tdata;   // [15:0] sample
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [15:0]                    o_m_tdata;   // [14:0] median, [15] zero
    logic                           o_m_tuser;   // [0] in_range

    // window model and limits
    logic [rgrm_pkg::DIST_W-1:0] win_vals [WIN];
    int unsigned                 win_slot;
    int unsigned                 win_fill;
    logic [rgrm_pkg::DIST_W-1:0] min_dist;
    logic [rgrm_pkg::DIST_W-1:0] max_dist;

    t_median_res pending_q [$];
    int          err_count;
    int          cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    range_gated_running_median #(
        .WINDOW (WIN)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gate the sample, push it into the window, rank the written entries
    function automatic t_median_res predict_median(input logic [15:0] smp);
        logic [rgrm_pkg::DIST_W-1:0] ranked [WIN];
        logic [rgrm_pkg::DIST_W-1:0] key;
        t_median_res                 res;
        int                          sval;
        int                          i;
        int                          j;
        sval         = int'($signed(smp));
        res.in_range = (sval >= int'(min_dist)) && (sval <= int'(max_dist));
        win_vals[win_slot] = res.in_range ? smp[rgrm_pkg::DIST_W-1:0] : max_dist;
        win_slot = (win_slot + 1) % WIN;
        if (win_fill < WIN) win_fill++;
        for (i = 0; i < int'(win_fill); i++) ranked[i] = win_vals[i];
        // insertion sort, ascending
        for (i = 1; i < int'(win_fill); i++) begin
            key = ranked[i];
            j   = i;
            while (j > 0 && ranked[j-1] > key) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = key;
        end
        res.median = ranked[win_fill / 2];
        return res;
    endfunction

    // random sample shaped around the current limits
    function automatic logic [15:0] rand_sample();
        logic [15:0] lo;
        logic [15:0] hi;
        lo = {1'b0, min_dist};
        hi = {1'b0, max_dist};
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                if (lo <= hi) return 16'($urandom_range(hi, lo));
                return {1'b0, 15'($urandom)};
            end
            4: begin
                case ($urandom_range(3))
                    0:       return lo - 16'd1;
                    1:       return lo;
                    2:       return hi;
                    default: return hi + 16'd1;
                endcase
            end
            5:       return TIMEOUT_SAMPLE;
            6:       return {1'b1, 15'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // one sample beat; the expectation is taken when the beat is accepted
    task automatic send_sample(input logic [15:0] smp, input logic has_exp,
                               input t_median_res typed_res);
        t_median_res res;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= smp;
        do @(posedge i_clk); while (!o_s_tready);
        res = predict_median(smp);
        pending_q.push_back(has_exp ? typed_res : res);
        // sender idles for a random stretch
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 16'($urandom);
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // hold the sender until every expected beat is back and the block is quiet
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rgrm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rgrm_pkg::DIST_W-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
        if (idx == rgrm_pkg::REG_MIN_DIST) min_dist = val;
        else max_dist = val;
    endtask

    task automatic apply_range(input logic [rgrm_pkg::DIST_W-1:0] lo,
                               input logic [rgrm_pkg::DIST_W-1:0] hi);
        wait_drained();
        write_reg(rgrm_pkg::REG_MIN_DIST, lo);
        write_reg(rgrm_pkg::REG_MAX_DIST, hi);
    endtask

    // result side: check accepted beats, randomize ready
    always @(posedge i_clk) begin : result_check
        t_median_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result beat: median %0d in_range %0d",
                       o_m_tdata[rgrm_pkg::DIST_W-1:0], o_m_tuser);
                err_count++;
            end else begin
                want = pending_q.pop_front();
                if (o_m_tuser !== want.in_range) begin
                    $error("in_range: expected %0d, got %0d", want.in_range, o_m_tuser);
                    err_count++;
                end
                if (o_m_tdata[rgrm_pkg::DIST_W-1:0] !== want.median) begin
                    $error("median: expected %0d, got %0d", want.median,
                           o_m_tdata[rgrm_pkg::DIST_W-1:0]);
                    err_count++;
                end
                if (o_m_tdata[15] !== 1'b0) begin
                    $error("tdata pad: expected 0, got %0b", o_m_tdata[15]);
                    err_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int r;
        int ph;
        int n;
        i_rst_n     <= 1'b0;
        i_cfg_wen   <= 1'b0;
        i_cfg_idx   <= rgrm_pkg::REG_MIN_DIST;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_m_tready  <= 1'b0;
        err_count     = 0;
        cycle_count   = 0;
        send_idle_pct = 38;
        recv_idle_pct = 61;
        // model state after reset
        min_dist = rgrm_pkg::MIN_DIST_RST;
        max_dist = rgrm_pkg::MAX_DIST_RST;
        win_slot = 0;
        win_fill = 0;
        for (r = 0; r < WIN; r++) win_vals[r] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (r = 0; r < DIR_ROWS_N; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                wait_drained();
                write_reg(DIR_ROWS[r].reg_idx, DIR_ROWS[r].value[rgrm_pkg::DIST_W-1:0]);
            end else begin
                send_sample(DIR_ROWS[r].value, DIR_ROWS[r].has_exp, DIR_ROWS[r].res);
            end
        end

        // random phases, one limit setting each
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 38;
                recv_idle_pct = 61;
            end else if (ph < 4) begin
                send_idle_pct = 61;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0:       apply_range(rgrm_pkg::MIN_DIST_RST, rgrm_pkg::MAX_DIST_RST);
                1:       apply_range(15'd0, 15'd0);
                2:       apply_range(15'd32767, 15'd32767);
                3:       apply_range(15'($urandom), 15'($urandom));
                4:       apply_range(15'd0, 15'd32767);
                default: apply_range(15'd1000, 15'd200);
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) send_sample(rand_sample(), 1'b0, '0);
        end

        wait_drained();
        if (err_count == 0 && pending_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
